// ===== rtl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;
    localparam int PIX_W = 24;
    localparam int CHAN_W = 8;
    localparam logic [10:0] WIDTH_RESET = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd480;
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ROOT,
        ST_OUT
    } state_t;

    // One channel's squared gradient from the eight neighbours of a 3x3 window.
    function automatic logic [16:0] grad_sq(input logic [7:0] l0, input logic [7:0] l1,
                                            input logic [7:0] l2, input logic [7:0] c0,
                                            input logic [7:0] c2, input logic [7:0] r0,
                                            input logic [7:0] r1, input logic [7:0] r2);
        logic signed [21:0] gx;
        logic signed [21:0] gy;
        logic [21:0] sq;
        gx = $signed({4'd0, r0}) - $signed({4'd0, l0}) + $signed({3'd0, r1, 1'b0})
             - $signed({3'd0, l1, 1'b0}) + $signed({4'd0, r2}) - $signed({4'd0, l2});
        gy = $signed({4'd0, l2}) + $signed({3'd0, c2, 1'b0}) + $signed({4'd0, r2})
             - $signed({4'd0, l0}) - $signed({3'd0, c0, 1'b0}) - $signed({4'd0, r0});
        sq = 22'(gx * gx) + 22'(gy * gy);
        return (sq > 22'd65279) ? 17'h1FFFF : sq[16:0];
    endfunction

    // Round a floor root up when s lies above r*r+r, saturated at 255.
    function automatic logic [7:0] round_root(input logic [16:0] s, input logic [7:0] r);
        if ({1'b0, s} > 18'(r) * 18'(r) + 18'(r) && r != 8'd255)
            return r + 8'd1;
        return r;
    endfunction
endpackage

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Top level: streaming 3x3 Sobel edge magnitude over RGB pixels.
// Each item passes through accept, line store read, gradient squares,
// eight square root steps (one bit per cycle), output.
// A new item is accepted only after the previous one has left the output state.
// A finished result sits in the output register; a stalled one holds the next item in output.
// Reset (rst_n, asynchronous) clears counters, window and state; line stores keep no reset.
// The output for pixel (r,c) appears frame_width+1 items later; the frame then needs flushes.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // end_of_frame, edge_red, edge_green, edge_blue
    output logic        m_axis_tlast,  // end_of_row
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_wdata
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 2) + 1;

    state_t state_reg, state_next;
    logic [10:0] width_cfg_reg, height_cfg_reg;
    logic [AW:0] col_reg;
    logic [HW-1:0] row_reg;
    pix_t px_reg;
    pix_t win_reg [6];
    pix_t col_now [3];
    pix_t up_rd, mid_rd;
    logic emit_reg, eor_reg, eof_reg;
    logic [CHAN_W-1:0] mag [3];
    logic [23:0] out_data_reg;
    logic out_eor_reg, out_eof_reg, out_valid_reg;
    logic [AW:0] w_use;
    logic [HW-1:0] h_use;
    pix_t zero3 [3];
    pix_t left_sel [3];
    pix_t cen_sel [3];
    pix_t right_sel [3];
    logic ls_we;
    logic root_last;

    // clamp registers into [2, MAX]
    always_comb
    begin
        if (width_cfg_reg < 11'd2)
            w_use = (AW+1)'(2);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            w_use = (AW+1)'(MAX_WIDTH);
        else
            w_use = (AW+1)'(width_cfg_reg);
        if (height_cfg_reg < 11'd2)
            h_use = HW'(2);
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            h_use = HW'(MAX_HEIGHT);
        else
            h_use = HW'(height_cfg_reg);
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign ls_we = (state_reg == ST_CALC);

    // line stores: both read in READ; in CALC the middle entry moves up and the pixel goes in
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(ls_we), .addr(col_reg[AW-1:0]), .wdata(mid_rd),
        .rdata(up_rd)
    );
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk(clk), .we(ls_we), .addr(col_reg[AW-1:0]), .wdata(px_reg),
        .rdata(mid_rd)
    );

    // column for this item, with rows outside the frame zeroed
    always_comb
    begin
        col_now[0] = (row_reg >= HW'(2) && row_reg - HW'(2) < h_use) ? up_rd : '0;
        col_now[1] = (row_reg >= HW'(1) && row_reg - HW'(1) < h_use) ? mid_rd : '0;
        col_now[2] = px_reg;
        for (int i = 0; i < 3; i++)
        begin
            zero3[i] = '0;
            left_sel[i] = (emit_reg && !eor_reg && col_reg >= (AW+1)'(2)) ? win_reg[i] : '0;
            if (eor_reg)
                left_sel[i] = win_reg[i];
            cen_sel[i] = win_reg[i+3];
            right_sel[i] = eor_reg ? zero3[i] : col_now[i];
        end
    end

    sem_mag u_mag (
        .clk(clk), .rst_n(rst_n), .left(left_sel), .cen(cen_sel), .right(right_sel),
        .sq_en(state_reg == ST_CALC), .root_last(root_last), .mag(mag)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_ROOT;
            ST_ROOT: if (root_last) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            width_cfg_reg <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            px_reg <= '0;
            out_valid_reg <= 1'b0;
            emit_reg <= 1'b0;
            eor_reg <= 1'b0;
            eof_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && state_next == ST_IDLE && emit_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_WIDTH)
                    width_cfg_reg <= cfg_wdata;
                else
                    height_cfg_reg <= cfg_wdata;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (state_reg == ST_CALC)
            begin
                if (col_reg == '0 && row_reg >= h_use + HW'(1))
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (col_reg + (AW+1)'(1) >= w_use)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + HW'(1);
                end
                else
                    col_reg <= col_reg + (AW+1)'(1);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                px_reg <= (32'(row_reg) < 32'(h_use) && !s_axis_tuser)
                          ? s_axis_tdata : '0;
                emit_reg <= (col_reg >= (AW+1)'(1) && row_reg >= HW'(1))
                            || (col_reg == '0 && row_reg >= HW'(2));
                eor_reg <= (col_reg == '0 && row_reg >= HW'(2));
                eof_reg <= (col_reg == '0 && row_reg == h_use + HW'(1));
            end
            if (state_reg == ST_CALC)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i] <= win_reg[i+3];
                    win_reg[i+3] <= col_now[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && state_next == ST_IDLE)
        begin
            out_data_reg <= {mag[2], mag[1], mag[0]};
            out_eor_reg <= eor_reg;
            out_eof_reg <= eof_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_eof_reg, out_data_reg};
    assign m_axis_tlast = out_eor_reg;
endmodule

// ===== rtl/sem_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/sem_mag.sv =====
// Window of three columns to three saturated edge magnitudes.
module sem_mag
    import sem_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pix_t                left [3],
    input  pix_t                cen [3],
    input  pix_t                right [3],
    input  logic                sq_en,
    output logic                root_last,
    output logic [CHAN_W-1:0]   mag [3]
);
    logic [16:0] sq_reg [3];
    logic [7:0]  root_reg [3];
    logic [7:0]  trial [3];
    logic [2:0]  step_reg;
    logic        run_reg;

    // one root bit per cycle, most significant first
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            trial[ch] = root_reg[ch] | (8'd1 << step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            step_reg <= '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                sq_reg[ch] <= '0;
                root_reg[ch] <= '0;
            end
        end
        else if (sq_en)
        begin
            run_reg <= 1'b1;
            step_reg <= 3'd7;
            for (int ch = 0; ch < 3; ch++)
            begin
                sq_reg[ch] <= grad_sq(left[0][ch*8 +: 8], left[1][ch*8 +: 8],
                                      left[2][ch*8 +: 8], cen[0][ch*8 +: 8],
                                      cen[2][ch*8 +: 8], right[0][ch*8 +: 8],
                                      right[1][ch*8 +: 8], right[2][ch*8 +: 8]);
                root_reg[ch] <= '0;
            end
        end
        else if (run_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if (17'(16'(trial[ch]) * 16'(trial[ch])) <= sq_reg[ch])
                    root_reg[ch] <= trial[ch];
            end
            if (step_reg == 3'd0)
                run_reg <= 1'b0;
            else
                step_reg <= step_reg - 3'd1;
        end
    end

    assign root_last = run_reg && (step_reg == 3'd0);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            mag[ch] = round_root(sq_reg[ch], root_reg[ch]);
    end
endmodule

// ===== rtl/sem_checker.sv =====
// Port-level checker for the Sobel block, bound to the top level.
module sem_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");
    a_eof_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tlast)
        else $error("end of frame without end of row");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken in consecutive cycles");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
